/* design/ffha_pkg.sv */
`default_nettype none

package ffha_pkg;

    localparam int MAX_EXTENTS_DEF = 16;
    localparam int HEADER_BYTES    = 4;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_START  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LENGTH = 1'd1;

    // operation kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_SPACE   = 2'd1;
    localparam logic [1:0] ST_TABLE_FULL = 2'd2;

    typedef struct packed {
        logic [15:0] start;
        logic [15:0] length;
    } t_extent;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SEED_ROOM,
        S_SEED_WR,
        S_A_START,
        S_A_RD,
        S_A_CHK,
        S_A_TAKE,
        S_R_CHK,
        S_R_RD,
        S_R_WR,
        S_F_BELOW,
        S_F_START,
        S_F_RD,
        S_F_CMP,
        S_F_NRD,
        S_F_NCAP,
        S_F_NEQ,
        S_F_NSUM,
        S_F_PRD,
        S_F_PCAP,
        S_F_PEQ,
        S_F_PSUM,
        S_F_ACT,
        S_I_CHK,
        S_I_RD,
        S_I_WR,
        S_I_PUT,
        S_FIN
    } t_state;

endpackage

`default_nettype wire

/* design/ffha_table.sv */
`default_nettype none

module ffha_table #(
    parameter int DEPTH = ffha_pkg::MAX_EXTENTS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire                   i_clk,
    input  wire                   i_we,
    input  wire [AW-1:0]          i_waddr,
    input  ffha_pkg::t_extent     i_wdata,
    input  wire [AW-1:0]          i_raddr,
    output ffha_pkg::t_extent     o_rdata
);

    ffha_pkg::t_extent r_mem [DEPTH];
    ffha_pkg::t_extent r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* design/first_fit_heap_allocator.sv */
// First-fit heap allocator with coalescing. Free space lives in an address-sorted
// table of MAX_EXTENTS (start, length) extents held in a single-port-read memory;
// one 17-bit adder/subtractor does the ordering compares and sums under a small
// sequencer. Each transaction on the input takes one result transaction on the
// output. The block takes one item at a time and holds o_stall high until that
// item's result is registered. Allocate walks the extents in address order from
// the first until one is large enough, then takes it; an exact fit removes the
// extent by moving each later entry down one place. Free checks the address
// against heap_start, finds the insert position, checks the following and then
// the preceding neighbour for a merge and rewrites a merged entry in place; with
// no merge it inserts by moving later entries up, and a merge with both removes
// one. Time is set by the table read per step, the shifting walk and any stall.
// The first transaction after reset, if an allocate, seeds from heap_start/heap_length.
`default_nettype none

module first_fit_heap_allocator #(
    parameter int MAX_EXTENTS = ffha_pkg::MAX_EXTENTS_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire [ffha_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire [15:0]                    i_cfg_data,
    input  wire                           i_valid,
    output logic                          o_stall,
    input  wire                           i_kind,
    input  wire [15:0]                    i_address,
    input  wire [15:0]                    i_length,
    output logic                          o_valid,
    input  wire                           i_stall,
    output logic [15:0]                   o_block_address,
    output logic [1:0]                    o_status,
    output logic                          o_below_start
);

    localparam int AW = $clog2(MAX_EXTENTS);
    localparam int CW = AW + 1;

    ffha_pkg::t_state r_state, n_state;

    logic [15:0]  r_heap_start, r_heap_length;
    logic [CW-1:0] r_count;
    logic          r_seeded;
    logic          r_out_valid;

    logic          r_kind;
    logic [15:0]   r_addr;
    logic [16:0]   r_size;
    logic [16:0]   r_sum;
    logic [15:0]   r_newlen;
    logic [CW-1:0] r_idx, r_pos;
    logic          r_mnext, r_flag;
    ffha_pkg::t_extent r_ent;
    logic [15:0]   r_block;
    logic [1:0]    r_status;
    logic          r_below;
    logic [15:0]   r_out_block;
    logic [1:0]    r_out_status;
    logic          r_out_below;

    logic          in_acc;
    logic [16:0]   n_size;
    logic [15:0]   base;
    logic [CW-1:0] idx_inc, idx_dec, pos_dec;
    logic          alu_lt;
    logic [15:0]   seed_len;

    // shared adder/subtractor
    logic [16:0]   alu_a, alu_b;
    logic          alu_sub;
    logic [17:0]   alu_res;

    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    ffha_pkg::t_extent mem_wdata, mem_rdata;

    ffha_table #(
        .DEPTH (MAX_EXTENTS),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign in_acc  = i_valid && !o_stall;
    assign o_stall = (r_state != ffha_pkg::S_IDLE);
    assign n_size  = (({1'b0, i_length} + 17'd3) & ~17'd3) + 17'(ffha_pkg::HEADER_BYTES);
    assign base    = {r_heap_start[15:2], 2'b00};
    assign idx_inc = r_idx + CW'(1);
    assign idx_dec = r_idx - CW'(1);
    assign pos_dec = r_pos - CW'(1);

    assign alu_res = {1'b0, alu_a} + (alu_sub ? ~{1'b0, alu_b} : {1'b0, alu_b})
                     + {17'd0, alu_sub};
    assign alu_lt  = alu_res[17];
    // smaller of heap_length and room left up to the top of the address space
    assign seed_len = alu_lt ? r_heap_length : r_sum[15:0];

    always_comb begin
        alu_a     = '0;
        alu_b     = '0;
        alu_sub   = 1'b0;
        mem_raddr = r_idx[AW-1:0];
        mem_we    = 1'b0;
        mem_waddr = r_idx[AW-1:0];
        mem_wdata = mem_rdata;
        unique case (r_state) inside
            ffha_pkg::S_SEED_ROOM: begin
                alu_a   = 17'h10000;
                alu_b   = {1'b0, base};
                alu_sub = 1'b1;
            end
            ffha_pkg::S_SEED_WR: begin
                alu_a     = {1'b0, r_heap_length};
                alu_b     = r_sum;
                alu_sub   = 1'b1;
                mem_we    = (seed_len != 16'd0);
                mem_waddr = '0;
                mem_wdata = '{start: base, length: seed_len};
            end
            ffha_pkg::S_A_CHK: begin
                alu_a   = {1'b0, mem_rdata.length};
                alu_b   = r_size;
                alu_sub = 1'b1;
            end
            ffha_pkg::S_A_TAKE: begin
                alu_a     = {1'b0, r_ent.start};
                alu_b     = r_size;
                mem_we    = (r_sum[15:0] != 16'd0);
                mem_wdata = '{start: alu_res[15:0], length: r_sum[15:0]};
            end
            ffha_pkg::S_R_RD: begin
                mem_raddr = idx_inc[AW-1:0];
            end
            ffha_pkg::S_R_WR, ffha_pkg::S_I_WR: begin
                mem_we = 1'b1;
            end
            ffha_pkg::S_F_BELOW: begin
                alu_a   = {1'b0, r_addr};
                alu_b   = {1'b0, base};
                alu_sub = 1'b1;
            end
            ffha_pkg::S_F_CMP: begin
                alu_a   = {1'b0, mem_rdata.start};
                alu_b   = {1'b0, r_addr};
                alu_sub = 1'b1;
            end
            ffha_pkg::S_F_NRD: begin
                mem_raddr = r_pos[AW-1:0];
            end
            ffha_pkg::S_F_NEQ: begin
                alu_a = {1'b0, r_addr};
                alu_b = r_size;
            end
            ffha_pkg::S_F_NSUM: begin
                alu_a = r_size;
                alu_b = {1'b0, r_ent.length};
            end
            ffha_pkg::S_F_PRD: begin
                mem_raddr = pos_dec[AW-1:0];
            end
            ffha_pkg::S_F_PEQ: begin
                alu_a = {1'b0, r_ent.start};
                alu_b = {1'b0, r_ent.length};
            end
            ffha_pkg::S_F_PSUM: begin
                alu_a     = {1'b0, r_ent.length};
                alu_b     = {1'b0, r_newlen};
                mem_we    = r_flag && !alu_res[16];
                mem_waddr = pos_dec[AW-1:0];
                mem_wdata = '{start: r_ent.start, length: alu_res[15:0]};
            end
            ffha_pkg::S_F_ACT: begin
                mem_we    = r_mnext;
                mem_waddr = r_pos[AW-1:0];
                mem_wdata = '{start: r_addr, length: r_newlen};
            end
            ffha_pkg::S_I_RD: begin
                mem_raddr = idx_dec[AW-1:0];
            end
            ffha_pkg::S_I_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos[AW-1:0];
                mem_wdata = '{start: r_addr, length: r_newlen};
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ffha_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (i_kind == ffha_pkg::KIND_FREE) begin
                        n_state = ffha_pkg::S_F_BELOW;
                    end else if (r_seeded) begin
                        n_state = ffha_pkg::S_A_START;
                    end else begin
                        n_state = ffha_pkg::S_SEED_ROOM;
                    end
                end
            end
            ffha_pkg::S_SEED_ROOM: n_state = ffha_pkg::S_SEED_WR;
            ffha_pkg::S_SEED_WR:   n_state = ffha_pkg::S_A_START;
            ffha_pkg::S_A_START: begin
                if (r_size[16] || r_count == '0) begin
                    n_state = ffha_pkg::S_FIN;
                end else begin
                    n_state = ffha_pkg::S_A_RD;
                end
            end
            ffha_pkg::S_A_RD: n_state = ffha_pkg::S_A_CHK;
            ffha_pkg::S_A_CHK: begin
                if (!alu_lt) begin
                    n_state = ffha_pkg::S_A_TAKE;
                end else if (idx_inc == r_count) begin
                    n_state = ffha_pkg::S_FIN;
                end else begin
                    n_state = ffha_pkg::S_A_RD;
                end
            end
            ffha_pkg::S_A_TAKE: begin
                n_state = (r_sum[15:0] != 16'd0) ? ffha_pkg::S_FIN : ffha_pkg::S_R_CHK;
            end
            ffha_pkg::S_R_CHK: begin
                n_state = (idx_inc < r_count) ? ffha_pkg::S_R_RD : ffha_pkg::S_FIN;
            end
            ffha_pkg::S_R_RD:    n_state = ffha_pkg::S_R_WR;
            ffha_pkg::S_R_WR:    n_state = ffha_pkg::S_R_CHK;
            ffha_pkg::S_F_BELOW: n_state = ffha_pkg::S_F_START;
            ffha_pkg::S_F_START: begin
                if (r_size[16] || r_size == '0) begin
                    n_state = ffha_pkg::S_FIN;
                end else if (r_count == '0) begin
                    n_state = ffha_pkg::S_F_ACT;
                end else begin
                    n_state = ffha_pkg::S_F_RD;
                end
            end
            ffha_pkg::S_F_RD: n_state = ffha_pkg::S_F_CMP;
            ffha_pkg::S_F_CMP: begin
                if (alu_lt) begin
                    n_state = (idx_inc == r_count) ? ffha_pkg::S_F_PRD : ffha_pkg::S_F_RD;
                end else if (r_idx == '0 && alu_res[16:0] == '0) begin
                    // same start as the first extent: goes after it
                    n_state = (r_count > CW'(1)) ? ffha_pkg::S_F_NRD : ffha_pkg::S_F_PRD;
                end else begin
                    n_state = ffha_pkg::S_F_NEQ;
                end
            end
            ffha_pkg::S_F_NRD:  n_state = ffha_pkg::S_F_NCAP;
            ffha_pkg::S_F_NCAP: n_state = ffha_pkg::S_F_NEQ;
            ffha_pkg::S_F_NEQ:  n_state = ffha_pkg::S_F_NSUM;
            ffha_pkg::S_F_NSUM: begin
                n_state = (r_pos != '0) ? ffha_pkg::S_F_PRD : ffha_pkg::S_F_ACT;
            end
            ffha_pkg::S_F_PRD:  n_state = ffha_pkg::S_F_PCAP;
            ffha_pkg::S_F_PCAP: n_state = ffha_pkg::S_F_PEQ;
            ffha_pkg::S_F_PEQ:  n_state = ffha_pkg::S_F_PSUM;
            ffha_pkg::S_F_PSUM: begin
                if (r_flag && !alu_res[16]) begin
                    n_state = r_mnext ? ffha_pkg::S_R_CHK : ffha_pkg::S_FIN;
                end else begin
                    n_state = ffha_pkg::S_F_ACT;
                end
            end
            ffha_pkg::S_F_ACT: begin
                if (r_mnext || r_count >= CW'(MAX_EXTENTS)) begin
                    n_state = ffha_pkg::S_FIN;
                end else begin
                    n_state = ffha_pkg::S_I_CHK;
                end
            end
            ffha_pkg::S_I_CHK: begin
                n_state = (r_idx > r_pos) ? ffha_pkg::S_I_RD : ffha_pkg::S_I_PUT;
            end
            ffha_pkg::S_I_RD:  n_state = ffha_pkg::S_I_WR;
            ffha_pkg::S_I_WR:  n_state = ffha_pkg::S_I_CHK;
            ffha_pkg::S_I_PUT: n_state = ffha_pkg::S_FIN;
            ffha_pkg::S_FIN: begin
                if (!r_out_valid || !i_stall) begin
                    n_state = ffha_pkg::S_IDLE;
                end
            end
            default: n_state = ffha_pkg::S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ffha_pkg::S_IDLE;
            r_heap_start  <= 16'd32768;
            r_heap_length <= 16'd32764;
            r_count       <= '0;
            r_seeded      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    ffha_pkg::CFG_HEAP_START:  r_heap_start  <= i_cfg_data;
                    ffha_pkg::CFG_HEAP_LENGTH: r_heap_length <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (in_acc) begin
                r_seeded <= 1'b1;
            end
            if (r_state == ffha_pkg::S_SEED_WR) begin
                r_count <= (seed_len != 16'd0) ? CW'(1) : '0;
            end
            if (r_state == ffha_pkg::S_R_CHK && !(idx_inc < r_count)) begin
                r_count <= r_count - CW'(1);
            end
            if (r_state == ffha_pkg::S_I_PUT) begin
                r_count <= r_count + CW'(1);
            end
            if (r_state == ffha_pkg::S_FIN && (!r_out_valid || !i_stall)) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers and result
    always_ff @(posedge i_clk) begin
        unique case (r_state) inside
            ffha_pkg::S_IDLE: begin
                if (in_acc) begin
                    r_kind   <= i_kind;
                    r_addr   <= i_address;
                    r_size   <= n_size;
                    r_status <= ffha_pkg::ST_OK;
                    r_block  <= '0;
                    r_below  <= 1'b0;
                end
            end
            ffha_pkg::S_SEED_ROOM: r_sum <= alu_res[16:0];
            ffha_pkg::S_A_START: begin
                r_idx <= '0;
                if (r_size[16] || r_count == '0) begin
                    r_status <= ffha_pkg::ST_NO_SPACE;
                end
            end
            ffha_pkg::S_A_CHK: begin
                r_ent <= mem_rdata;
                if (!alu_lt) begin
                    r_sum <= alu_res[16:0];
                end else begin
                    r_idx <= idx_inc;
                    if (idx_inc == r_count) begin
                        r_status <= ffha_pkg::ST_NO_SPACE;
                    end
                end
            end
            ffha_pkg::S_A_TAKE:  r_block <= r_ent.start;
            ffha_pkg::S_R_WR:    r_idx <= idx_inc;
            ffha_pkg::S_F_BELOW: r_below <= alu_lt;
            ffha_pkg::S_F_START: begin
                r_idx    <= '0;
                r_pos    <= '0;
                r_mnext  <= 1'b0;
                r_newlen <= r_size[15:0];
                if (r_size[16]) begin
                    r_status <= ffha_pkg::ST_NO_SPACE;
                end
            end
            ffha_pkg::S_F_CMP: begin
                r_ent <= mem_rdata;
                if (alu_lt) begin
                    r_idx <= idx_inc;
                    r_pos <= idx_inc;
                end else if (r_idx == '0 && alu_res[16:0] == '0) begin
                    r_pos <= CW'(1);
                end else begin
                    r_pos <= r_idx;
                end
            end
            ffha_pkg::S_F_NCAP, ffha_pkg::S_F_PCAP: r_ent <= mem_rdata;
            ffha_pkg::S_F_NEQ: r_flag <= (alu_res[16:0] == {1'b0, r_ent.start});
            ffha_pkg::S_F_NSUM: begin
                // merge with the following extent only if the sum still fits
                if (r_flag && !alu_res[16]) begin
                    r_mnext  <= 1'b1;
                    r_newlen <= alu_res[15:0];
                end
            end
            ffha_pkg::S_F_PEQ: r_flag <= (alu_res[16:0] == {1'b0, r_addr});
            ffha_pkg::S_F_PSUM: begin
                if (r_flag && !alu_res[16] && r_mnext) begin
                    r_idx <= r_pos;
                end
            end
            ffha_pkg::S_F_ACT: begin
                if (!r_mnext) begin
                    if (r_count >= CW'(MAX_EXTENTS)) begin
                        r_status <= ffha_pkg::ST_TABLE_FULL;
                    end else begin
                        r_idx <= r_count;
                    end
                end
            end
            ffha_pkg::S_I_WR: r_idx <= idx_dec;
            ffha_pkg::S_FIN: begin
                if (!r_out_valid || !i_stall) begin
                    r_out_block  <= (r_kind == ffha_pkg::KIND_ALLOC) ? r_block : 16'd0;
                    r_out_status <= r_status;
                    r_out_below  <= r_below;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid         = r_out_valid;
    assign o_block_address = r_out_block;
    assign o_status        = r_out_status;
    assign o_below_start   = r_out_below;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_EXTENTS))
        else $error("extent count above table depth");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != ffha_pkg::S_IDLE))
        else $error("sequencer did not leave idle after a transaction");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ffha_pkg::S_FIN))
        else $error("result raised outside the finish step");

endmodule

`default_nettype wire
